// ===== rtl/hrl_pkg.sv =====
// ============================================================================
// hrl_pkg
// Shared types and codes of the hex record loader.
// ============================================================================
package hrl_pkg;

    localparam logic [31:0] MEMORY_LIMIT_RESET = 32'd1024;

    localparam logic [1:0] KIND_WRITE = 2'd0;
    localparam logic [1:0] KIND_END   = 2'd1;
    localparam logic [1:0] KIND_ERROR = 2'd2;

    localparam logic [2:0] ERR_NONE = 3'd0;
    localparam logic [2:0] ERR_CHAR = 3'd1;
    localparam logic [2:0] ERR_TYPE = 3'd2;
    localparam logic [2:0] ERR_ADDR = 3'd3;
    localparam logic [2:0] ERR_SUM  = 3'd4;

    typedef struct packed {
        logic       is_space;
        logic       is_colon;
        logic       is_hex;
        logic [3:0] value;
    } char_class_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] address;
        logic [7:0]  data;
        logic [2:0]  error_code;
    } result_t;

endpackage

// ===== rtl/hrl_char_decode.sv =====
// ============================================================================
// hrl_char_decode
// Classifies one ASCII character as whitespace, colon or hex digit.
// ============================================================================
module hrl_char_decode (
    input  logic [7:0]           character,
    output hrl_pkg::char_class_t char_class
);

    always_comb
    begin
        char_class          = '0;
        char_class.is_space = character inside {8'h20, 8'h09, 8'h0a, 8'h0b, 8'h0c, 8'h0d};
        char_class.is_colon = (character == 8'h3a);
        if (character inside {[8'h30:8'h39]})
        begin
            char_class.is_hex = 1'b1;
            char_class.value  = 4'(character - 8'h30);
        end
        else if (character inside {[8'h41:8'h46]})
        begin
            char_class.is_hex = 1'b1;
            char_class.value  = 4'(character - 8'h37);
        end
        else if (character inside {[8'h61:8'h66]})
        begin
            char_class.is_hex = 1'b1;
            char_class.value  = 4'(character - 8'h57);
        end
    end

endmodule

// ===== rtl/hrl_parser.sv =====
// ============================================================================
// hrl_parser
// Record parser state and the result of one character.
// ============================================================================
module hrl_parser (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 step,
    input  hrl_pkg::char_class_t char_class,
    input  logic [31:0]          memory_limit,
    output logic                 result_valid,
    output hrl_pkg::result_t     result
);

    localparam logic [2:0] PH_COLON = 3'd0;
    localparam logic [2:0] PH_LEN   = 3'd1;
    localparam logic [2:0] PH_ADDR  = 3'd2;
    localparam logic [2:0] PH_TYPE  = 3'd3;
    localparam logic [2:0] PH_DATA  = 3'd4;
    localparam logic [2:0] PH_EXT   = 3'd5;
    localparam logic [2:0] PH_SUM   = 3'd6;

    logic [2:0]  phase_reg, phase_next;
    logic [3:0]  upper_reg, upper_next;
    logic        pending_reg, pending_next;
    logic [7:0]  length_reg, length_next;
    logic [15:0] rec_addr_reg, rec_addr_next;
    logic [7:0]  type_reg, type_next;
    logic [7:0]  count_reg, count_next;
    logic [15:0] ext_reg, ext_next;
    logic [31:0] base_reg, base_next;
    logic [7:0]  sum_reg, sum_next;
    logic        halted_reg, halted_next;

    logic [7:0]  byte_value;
    logic [7:0]  count_inc;
    logic [31:0] write_addr;

    assign byte_value = {upper_reg, char_class.value};
    assign count_inc  = count_reg + 8'd1;
    assign write_addr = base_reg + {16'd0, rec_addr_reg} + {24'd0, count_reg};

    always_comb
    begin
        phase_next    = phase_reg;
        upper_next    = upper_reg;
        pending_next  = pending_reg;
        length_next   = length_reg;
        rec_addr_next = rec_addr_reg;
        type_next     = type_reg;
        count_next    = count_reg;
        ext_next      = ext_reg;
        base_next     = base_reg;
        sum_next      = sum_reg;
        halted_next   = halted_reg;
        result_valid  = 1'b0;
        result        = '0;

        if (step && !halted_reg && !char_class.is_space)
        begin
            if (phase_reg == PH_COLON)
            begin
                if (!char_class.is_colon)
                begin
                    halted_next       = 1'b1;
                    result_valid      = 1'b1;
                    result.kind       = hrl_pkg::KIND_ERROR;
                    result.error_code = hrl_pkg::ERR_CHAR;
                end
                else
                begin
                    phase_next    = PH_LEN;
                    sum_next      = 8'd0;
                    rec_addr_next = 16'd0;
                    pending_next  = 1'b0;
                    upper_next    = 4'd0;
                end
            end
            else if (!char_class.is_hex)
            begin
                halted_next       = 1'b1;
                result_valid      = 1'b1;
                result.kind       = hrl_pkg::KIND_ERROR;
                result.error_code = hrl_pkg::ERR_CHAR;
            end
            else if (!pending_reg)
            begin
                upper_next   = char_class.value;
                pending_next = 1'b1;
            end
            else
            begin
                pending_next = 1'b0;
                sum_next     = sum_reg + byte_value;
                case (phase_reg)
                    PH_LEN:
                    begin
                        length_next = byte_value;
                        count_next  = 8'd0;
                        phase_next  = PH_ADDR;
                    end
                    PH_ADDR:
                    begin
                        rec_addr_next = {rec_addr_reg[7:0], byte_value};
                        count_next    = count_inc;
                        if (count_inc >= 8'd2)
                        begin
                            phase_next = PH_TYPE;
                        end
                    end
                    PH_TYPE:
                    begin
                        type_next  = byte_value;
                        count_next = 8'd0;
                        if (byte_value == 8'd0)
                        begin
                            phase_next = (length_reg == 8'd0) ? PH_SUM : PH_DATA;
                        end
                        else if (byte_value == 8'd1)
                        begin
                            phase_next = PH_SUM;
                        end
                        else if (byte_value == 8'd2 || byte_value == 8'd4)
                        begin
                            ext_next   = 16'd0;
                            phase_next = PH_EXT;
                        end
                        else
                        begin
                            halted_next       = 1'b1;
                            result_valid      = 1'b1;
                            result.kind       = hrl_pkg::KIND_ERROR;
                            result.error_code = hrl_pkg::ERR_TYPE;
                        end
                    end
                    PH_DATA:
                    begin
                        result_valid = 1'b1;
                        if (write_addr >= memory_limit)
                        begin
                            halted_next       = 1'b1;
                            result.kind       = hrl_pkg::KIND_ERROR;
                            result.error_code = hrl_pkg::ERR_ADDR;
                        end
                        else
                        begin
                            count_next     = count_inc;
                            result.kind    = hrl_pkg::KIND_WRITE;
                            result.address = write_addr;
                            result.data    = byte_value;
                            if (count_inc >= length_reg)
                            begin
                                phase_next = PH_SUM;
                            end
                        end
                    end
                    PH_EXT:
                    begin
                        ext_next   = {ext_reg[7:0], byte_value};
                        count_next = count_inc;
                        if (count_inc >= 8'd2)
                        begin
                            if (type_reg == 8'd2)
                            begin
                                base_next = {12'd0, ext_reg[7:0], byte_value, 4'd0};
                            end
                            else
                            begin
                                base_next = {ext_reg[7:0], byte_value, 16'd0};
                            end
                            phase_next = PH_SUM;
                        end
                    end
                    default:
                    begin
                        if (sum_next != 8'd0)
                        begin
                            halted_next       = 1'b1;
                            result_valid      = 1'b1;
                            result.kind       = hrl_pkg::KIND_ERROR;
                            result.error_code = hrl_pkg::ERR_SUM;
                        end
                        else
                        begin
                            phase_next = PH_COLON;
                            if (type_reg == 8'd1)
                            begin
                                halted_next  = 1'b1;
                                result_valid = 1'b1;
                                result.kind  = hrl_pkg::KIND_END;
                            end
                        end
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_COLON;
            upper_reg    <= 4'd0;
            pending_reg  <= 1'b0;
            length_reg   <= 8'd0;
            rec_addr_reg <= 16'd0;
            type_reg     <= 8'd0;
            count_reg    <= 8'd0;
            ext_reg      <= 16'd0;
            base_reg     <= 32'd0;
            sum_reg      <= 8'd0;
            halted_reg   <= 1'b0;
        end
        else
        begin
            phase_reg    <= phase_next;
            upper_reg    <= upper_next;
            pending_reg  <= pending_next;
            length_reg   <= length_next;
            rec_addr_reg <= rec_addr_next;
            type_reg     <= type_next;
            count_reg    <= count_next;
            ext_reg      <= ext_next;
            base_reg     <= base_next;
            sum_reg      <= sum_next;
            halted_reg   <= halted_next;
        end
    end

endmodule

// ===== rtl/hex_record_loader_unit.sv =====
// ============================================================================
// hex_record_loader_unit
// Streaming Intel HEX parser that turns text into memory byte writes.
// ============================================================================
//   Channel   Signals                                  Direction
//   input     in_valid, in_ready, character            in
//   output    out_valid, out_ready, kind, address,     out
//             data, error_code
//   config    cfg_write_en, cfg_write_data             in
//
// One character is taken per cycle while in_ready is high; it is held in the input
// register, and its result, if any, is presented from the result register.
// Reset loads a memory limit of 1024 and leaves the parser waiting for a colon.
// While a result waits with out_ready low the result register and parser hold;
// one more item is buffered in the input register, and then in_ready falls.
// After the end record or any error no further results are given until reset.
module hex_record_loader_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  character,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  kind,
    output logic [31:0] address,
    output logic [7:0]  data,
    output logic [2:0]  error_code,
    input  logic        cfg_write_en,
    input  logic [31:0] cfg_write_data
);

    logic                 in_valid_reg;
    logic [7:0]           char_reg;
    logic [31:0]          limit_reg;
    logic                 out_valid_reg;
    hrl_pkg::result_t     result_reg;

    logic                 advance;
    logic                 step;
    hrl_pkg::char_class_t char_class;
    logic                 result_valid;
    hrl_pkg::result_t     result;

    assign advance  = !out_valid_reg || out_ready;
    assign step     = in_valid_reg && advance;
    assign in_ready = !in_valid_reg || advance;

    hrl_char_decode u_decode (
        .character  (char_reg),
        .char_class (char_class)
    );

    hrl_parser u_parser (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (step),
        .char_class   (char_class),
        .memory_limit (limit_reg),
        .result_valid (result_valid),
        .result       (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            limit_reg     <= hrl_pkg::MEMORY_LIMIT_RESET;
        end
        else
        begin
            if (in_ready)
            begin
                in_valid_reg <= in_valid;
            end
            if (advance)
            begin
                out_valid_reg <= step && result_valid;
            end
            if (cfg_write_en)
            begin
                limit_reg <= cfg_write_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            char_reg <= character;
        end
        if (advance)
        begin
            result_reg <= result;
        end
    end

    assign out_valid  = out_valid_reg;
    assign kind       = result_reg.kind;
    assign address    = result_reg.address;
    assign data       = result_reg.data;
    assign error_code = result_reg.error_code;

endmodule

// ===== sim/hex_record_loader_unit_test.sv =====
// ============================================================================
// hex_record_loader_unit_test
// Self-checking testbench for the streaming Intel HEX record loader.
// A tracker class parses every accepted character on its own and queues the
// memory writes, end marker and error it predicts. Each result that leaves
// the block is compared with the oldest queued one. The text is built from
// well-formed records with random content, case and embedded whitespace under
// several memory limits and handshake idling patterns. The run closes with
// one randomly chosen halting event and some ignored characters.
// ============================================================================
`timescale 1ns / 100ps

typedef logic [7:0] octet_t;

typedef enum logic [7:0] {
    REC_DATA    = 8'd0,
    REC_EOF     = 8'd1,
    REC_SEGMENT = 8'd2,
    REC_LINEAR  = 8'd4
} record_code_t;

typedef enum logic [2:0] {
    AWAIT_COLON,
    GET_LENGTH,
    GET_ADDRESS,
    GET_TYPE,
    GET_DATA,
    GET_EXTENSION,
    GET_CHECKSUM
} parse_phase_t;

localparam logic [7:0] COLON_CHAR = 8'h3A;

function automatic int digit_value(logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39)
        return int'(c - 8'h30);
    if (c >= 8'h41 && c <= 8'h46)
        return int'(c - 8'h37);
    if (c >= 8'h61 && c <= 8'h66)
        return int'(c - 8'h57);
    return -1;
endfunction

function automatic bit is_blank(logic [7:0] c);
    return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
endfunction

class hex_image_tracker;
    logic [31:0]      memory_limit;
    parse_phase_t     phase;
    logic [3:0]       upper_nibble;
    logic             nibble_pending;
    logic [7:0]       record_length;
    logic [15:0]      record_address;
    logic [7:0]       record_code;
    logic [7:0]       byte_count;
    logic [15:0]      extension;
    logic [31:0]      base_offset;
    logic [7:0]       running_sum;
    logic             halted;
    hrl_pkg::result_t pending_loads[$];
    int               faults;

    function new();
        memory_limit   = hrl_pkg::MEMORY_LIMIT_RESET;
        phase          = AWAIT_COLON;
        upper_nibble   = '0;
        nibble_pending = 1'b0;
        record_length  = '0;
        record_address = '0;
        record_code    = '0;
        byte_count     = '0;
        extension      = '0;
        base_offset    = '0;
        running_sum    = '0;
        halted         = 1'b0;
        faults         = 0;
    endfunction

    function void set_limit(logic [31:0] value);
        memory_limit = value;
    endfunction

    function void raise_error(logic [2:0] code);
        halted = 1'b1;
        pending_loads.push_back('{kind: hrl_pkg::KIND_ERROR, address: '0, data: '0,
                                  error_code: code});
    endfunction

    function void take_byte(logic [7:0] value);
        logic [31:0] target;
        running_sum = running_sum + value;
        case (phase)
            GET_LENGTH:
            begin
                record_length = value;
                byte_count    = '0;
                phase         = GET_ADDRESS;
            end
            GET_ADDRESS:
            begin
                record_address = {record_address[7:0], value};
                byte_count++;
                if (byte_count >= 2)
                    phase = GET_TYPE;
            end
            GET_TYPE:
            begin
                record_code = value;
                byte_count  = '0;
                if (value == REC_DATA)
                    phase = (record_length == 0) ? GET_CHECKSUM : GET_DATA;
                else if (value == REC_EOF)
                    phase = GET_CHECKSUM;
                else if (value == REC_SEGMENT || value == REC_LINEAR)
                begin
                    extension = '0;
                    phase     = GET_EXTENSION;
                end
                else
                    raise_error(hrl_pkg::ERR_TYPE);
            end
            GET_DATA:
            begin
                target = base_offset + {16'h0000, record_address} + {24'h000000, byte_count};
                if (target >= memory_limit)
                    raise_error(hrl_pkg::ERR_ADDR);
                else
                begin
                    byte_count++;
                    if (byte_count >= record_length)
                        phase = GET_CHECKSUM;
                    pending_loads.push_back('{kind: hrl_pkg::KIND_WRITE, address: target,
                                              data: value, error_code: hrl_pkg::ERR_NONE});
                end
            end
            GET_EXTENSION:
            begin
                extension = {extension[7:0], value};
                byte_count++;
                if (byte_count >= 2)
                begin
                    if (record_code == REC_SEGMENT)
                        base_offset = {12'h000, extension, 4'h0};
                    else
                        base_offset = {extension, 16'h0000};
                    phase = GET_CHECKSUM;
                end
            end
            default:
            begin
                if (running_sum != 0)
                    raise_error(hrl_pkg::ERR_SUM);
                else
                begin
                    phase = AWAIT_COLON;
                    if (record_code == REC_EOF)
                    begin
                        halted = 1'b1;
                        pending_loads.push_back('{kind: hrl_pkg::KIND_END, address: '0,
                                                  data: '0, error_code: hrl_pkg::ERR_NONE});
                    end
                end
            end
        endcase
    endfunction

    function void track_char(logic [7:0] c);
        int digit;
        if (halted || is_blank(c))
            return;
        if (phase == AWAIT_COLON)
        begin
            if (c != COLON_CHAR)
            begin
                raise_error(hrl_pkg::ERR_CHAR);
                return;
            end
            phase          = GET_LENGTH;
            running_sum    = '0;
            record_address = '0;
            nibble_pending = 1'b0;
            upper_nibble   = '0;
            return;
        end
        digit = digit_value(c);
        if (digit < 0)
        begin
            raise_error(hrl_pkg::ERR_CHAR);
            return;
        end
        if (!nibble_pending)
        begin
            upper_nibble   = digit[3:0];
            nibble_pending = 1'b1;
            return;
        end
        nibble_pending = 1'b0;
        take_byte({upper_nibble, digit[3:0]});
    endfunction

    function void log_fault(string what, hrl_pkg::result_t want, hrl_pkg::result_t got);
        faults++;
        if (faults <= 10)
            $display({"%s: expected kind %0d address %h data %h code %0d, ",
                      "got kind %0d address %h data %h code %0d"},
                     what, want.kind, want.address, want.data, want.error_code,
                     got.kind, got.address, got.data, got.error_code);
    endfunction

    function void compare_load(hrl_pkg::result_t got);
        hrl_pkg::result_t want;
        if (pending_loads.size() == 0)
        begin
            log_fault("unexpected result", '0, got);
            return;
        end
        want = pending_loads.pop_front();
        if (got.kind !== want.kind || got.address !== want.address ||
            got.data !== want.data || got.error_code !== want.error_code)
            log_fault("mismatch", want, got);
    endfunction
endclass

module hex_record_loader_unit_test;

    localparam int CYCLE_LIMIT     = 200000;
    localparam int HOLD_OFF_CYCLES = 200;
    localparam logic [7:0] BLANKS [6] = '{8'h20, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D};

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  character;
    logic        out_valid;
    logic        out_ready;
    logic [1:0]  kind;
    logic [31:0] address;
    logic [7:0]  data;
    logic [2:0]  error_code;
    logic        cfg_write_en;
    logic [31:0] cfg_write_data;

    hex_image_tracker tracker;
    int               sender_idle_pct;
    int               receiver_idle_pct;
    bit               hold_off_request;
    int               sent_chars;
    int               cycle_count;
    logic [31:0]      gen_base;
    logic [31:0]      gen_limit;

    hex_record_loader_unit dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .character      (character),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .kind           (kind),
        .address        (address),
        .data           (data),
        .error_code     (error_code),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_off_request)
            begin
                out_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(negedge clk);
                hold_off_request = 1'b0;
            end
            out_ready <= ($urandom_range(0, 99) >= receiver_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            tracker.compare_load({kind, address, data, error_code});
    end

    task automatic send_char(input logic [7:0] c);
        int gap;
        gap = 0;
        while ($urandom_range(0, 99) < sender_idle_pct)
            gap++;
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid  <= 1'b1;
        character <= c;
        do
            @(posedge clk);
        while (!in_ready);
        tracker.track_char(c);
        sent_chars++;
    endtask

    function automatic logic [7:0] hex_char(input logic [3:0] nibble);
        if (nibble < 10)
            return 8'h30 + {4'h0, nibble};
        return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + {4'h0, nibble} - 8'd10;
    endfunction

    task automatic maybe_blank();
        if ($urandom_range(0, 9) == 0)
            send_char(BLANKS[3'($urandom_range(0, 5))]);
    endtask

    task automatic send_hex(input logic [7:0] value);
        maybe_blank();
        send_char(hex_char(value[7:4]));
        maybe_blank();
        send_char(hex_char(value[3:0]));
    endtask

    task automatic send_record(input octet_t body[$], input bit corrupt);
        logic [7:0] check_byte;
        check_byte = 8'h00;
        foreach (body[i])
            check_byte += body[i];
        check_byte = -check_byte;
        if (corrupt)
            check_byte += 8'($urandom_range(1, 255));
        maybe_blank();
        send_char(COLON_CHAR);
        foreach (body[i])
            send_hex(body[i]);
        send_hex(check_byte);
    endtask

    function automatic bit fits(input logic [15:0] origin, input logic [7:0] count);
        logic [31:0] target;
        for (int i = 0; i < count; i++)
        begin
            target = gen_base + {16'h0000, origin} + 32'(i);
            if (target >= gen_limit)
                return 1'b0;
        end
        return 1'b1;
    endfunction

    // Data records are placed so that every byte lands below the memory limit.
    task automatic send_data_record(input bit corrupt);
        octet_t      body[$];
        logic [7:0]  count;
        logic [15:0] origin;
        logic [31:0] room;
        bit          placed;
        count  = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
                                              : 8'($urandom_range(0, 16));
        room   = (gen_limit > gen_base) ? gen_limit - gen_base : 32'd0;
        placed = 1'b0;
        origin = '0;
        for (int t = 0; t < 8 && !placed; t++)
        begin
            if (t % 2 == 0 && room != 0)
                origin = 16'($urandom_range(0, (room > 32'd65536) ? 65535 : room - 1));
            else
                origin = 16'($urandom_range(0, 65535));
            placed = fits(origin, count);
        end
        if (!placed)
            count = 0;
        body = '{count, origin[15:8], origin[7:0], REC_DATA};
        repeat (count) body.push_back(8'($urandom_range(0, 255)));
        send_record(body, corrupt);
    endtask

    task automatic send_extension_record(input bit corrupt);
        octet_t      body[$];
        bit          segment;
        logic [15:0] ext;
        logic [31:0] top;
        segment = 1'($urandom_range(0, 1));
        case ($urandom_range(0, 5))
            0: ext = 16'h0000;
            1: ext = 16'hFFFF;
            2: ext = 16'($urandom_range(0, 65535));
            default:
            begin
                top = gen_limit >> (segment ? 4 : 16);
                ext = 16'($urandom_range(0, (top > 32'd65535) ? 65535 : top));
            end
        endcase
        body = '{8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                 8'($urandom_range(0, 255)),
                 segment ? REC_SEGMENT : REC_LINEAR, ext[15:8], ext[7:0]};
        gen_base = segment ? {12'h000, ext, 4'h0} : {ext, 16'h0000};
        send_record(body, corrupt);
    endtask

    task automatic settle_block();
        int ready_cycles;
        @(negedge clk);
        in_valid <= 1'b0;
        while (tracker.pending_loads.size() != 0)
            @(posedge clk);
        ready_cycles = 0;
        while (ready_cycles < 4)
        begin
            @(posedge clk);
            if (out_ready)
                ready_cycles++;
        end
    endtask

    task automatic write_limit(input logic [31:0] value);
        @(negedge clk);
        cfg_write_en   <= 1'b1;
        cfg_write_data <= value;
        @(negedge clk);
        cfg_write_en <= 1'b0;
        tracker.set_limit(value);
        gen_limit = value;
    endtask

    task automatic run_phase(input logic [31:0] limit, input int count, input int sender_pct,
                             input int receiver_pct, input bit pressure);
        int target;
        settle_block();
        write_limit(limit);
        sender_idle_pct   = sender_pct;
        receiver_idle_pct = receiver_pct;
        hold_off_request  = pressure;
        target = sent_chars + count;
        while (sent_chars < target)
        begin
            if ($urandom_range(0, 9) < 7)
                send_data_record(1'b0);
            else
                send_extension_record(1'b0);
        end
    endtask

    // The block halts for good after this, so only one such event fits in a run.
    task automatic finish_image();
        octet_t     body[$];
        logic [7:0] c;
        int         pick;
        pick = $urandom_range(0, 6);
        case (pick)
            0:
            begin
                body = '{8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                         8'($urandom_range(0, 255)), REC_EOF};
                send_record(body, 1'b0);
            end
            1:
            begin
                do
                    c = 8'($urandom_range(0, 255));
                while (is_blank(c) || c == COLON_CHAR);
                send_char(c);
            end
            2, 3:
            begin
                send_char(COLON_CHAR);
                repeat ($urandom_range(0, 3)) send_hex(8'($urandom_range(0, 255)));
                if ($urandom_range(0, 1))
                    send_char(hex_char(4'($urandom_range(0, 15))));
                if (pick == 2)
                    send_char(COLON_CHAR);
                else
                begin
                    do
                        c = 8'($urandom_range(0, 255));
                    while (is_blank(c) || digit_value(c) >= 0);
                    send_char(c);
                end
            end
            4:
            begin
                do
                    c = 8'($urandom_range(0, 255));
                while (c == REC_DATA || c == REC_EOF || c == REC_SEGMENT || c == REC_LINEAR);
                body = '{8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                         8'($urandom_range(0, 255)), c};
                send_record(body, 1'b0);
            end
            5:
            begin
                // The first data byte then lands on the top address, which no limit admits.
                body = '{8'($urandom_range(0, 255)), 8'h00, 8'h00, REC_LINEAR, 8'hFF, 8'hFF};
                send_record(body, 1'b0);
                body = '{8'($urandom_range(1, 4)), 8'hFF, 8'hFF, REC_DATA,
                         8'($urandom_range(0, 255))};
                send_record(body, 1'b0);
            end
            default:
            begin
                case ($urandom_range(0, 2))
                    0: send_data_record(1'b1);
                    1: send_extension_record(1'b1);
                    default:
                    begin
                        body = '{8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                                 8'($urandom_range(0, 255)), REC_EOF};
                        send_record(body, 1'b1);
                    end
                endcase
            end
        endcase
    endtask

    initial
    begin
        string directed_text;
        rst_n             = 1'b0;
        in_valid          = 1'b0;
        character         = 8'h00;
        cfg_write_en      = 1'b0;
        cfg_write_data    = 32'h0000_0000;
        hold_off_request  = 1'b0;
        sent_chars        = 0;
        gen_base          = 32'h0000_0000;
        gen_limit         = hrl_pkg::MEMORY_LIMIT_RESET;
        sender_idle_pct   = 36;
        receiver_idle_pct = 71;
        tracker           = new();
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // An empty data record split by whitespace, then one byte at the last
        // address below the reset limit in lowercase digits.
        directed_text = {":00 000000\t0\n0", ":0103ff00fffe"};
        for (int k = 0; k < directed_text.len(); k++)
            send_char(directed_text[k]);

        run_phase(32'hFFFF_FFFF, 350, 36, 71, 1'b0);
        run_phase(32'h0000_0000, 80, 36, 71, 1'b0);
        run_phase($urandom_range(16, 4096), 400, 71, 36, 1'b0);
        run_phase(hrl_pkg::MEMORY_LIMIT_RESET, 300, 0, 0, 1'b1);
        run_phase($urandom, 350, 0, 0, 1'b0);

        finish_image();
        for (int k = 0; k < 32; k++)
            send_char((k == 0) ? 8'h00 : (k == 1) ? 8'hFF : 8'($urandom_range(0, 255)));

        @(negedge clk);
        in_valid <= 1'b0;
        while (tracker.pending_loads.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (tracker.faults == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
